// ===== sv/tscf_pkg.sv =====
// Types and codes for the server connection table: event and result
// transfer structs, event/segment/reply/status codes, slot state encoding.
// No dependencies.
package tscf_pkg;

  typedef enum logic [2:0] {
    MODE_SEG    = 3'd0,
    MODE_OPEN   = 3'd1,
    MODE_LISTEN = 3'd2,
    MODE_READ   = 3'd3,
    MODE_CLOSE  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    SEG_SYN     = 3'd0,
    SEG_SYNACK  = 3'd1,
    SEG_FIN     = 3'd2,
    SEG_FINACK  = 3'd3,
    SEG_DATA    = 3'd4,
    SEG_DATAACK = 3'd5
  } seg_type_e;

  typedef enum logic [1:0] {
    RP_SYNACK  = 2'd0,
    RP_FINACK  = 2'd1,
    RP_DATAACK = 2'd2
  } reply_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SLOT   = 2'd1,
    STAT_DROP      = 2'd2,
    STAT_NOT_READY = 2'd3
  } status_e;

  // Connection state of one slot, one-hot in the table
  typedef enum logic [3:0] {
    CS_CLOSED = 4'b0001,
    CS_LISTEN = 4'b0010,
    CS_CONN   = 4'b0100,
    CS_CWAIT  = 4'b1000
  } conn_state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  slot;
    logic [15:0] open_port;
    logic [2:0]  seg_type;
    logic [15:0] cli_port;
    logic [15:0] srv_port;
    logic [7:0]  src_node;
    logic [31:0] seq_num;
    logic [10:0] seg_len;
    logic [16:0] read_len;
  } in_t;

  typedef struct packed {
    logic        send_reply;
    logic [1:0]  reply_type;
    logic [15:0] reply_from_port;
    logic [15:0] reply_to_port;
    logic [7:0]  reply_node;
    logic [31:0] ack_num;
    logic        accept_data;
    logic [15:0] write_offset;
    logic [2:0]  slot_out;
    logic [1:0]  slot_state;
    logic [1:0]  status;
    logic [16:0] buf_used;
  } out_t;

  // Map the one-hot slot state to its 2-bit report code
  function automatic logic [1:0] cs_code(conn_state_e st);
    logic [1:0] code;
    unique case (st)
      CS_CLOSED: code = 2'd0;
      CS_LISTEN: code = 2'd1;
      CS_CONN:   code = 2'd2;
      CS_CWAIT:  code = 2'd3;
      default:   code = 2'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/transport_server_connection_fsm.sv =====
// Server connection table: slot registers, port match, per-event update.
// Depends on tscf_pkg.
//
// One event is taken in every clock cycle (busy_o stays low). An event
// accepted at one edge is registered there, handled against the slot table
// in the following cycle, and its result is driven on result_o with done_o
// high for the one cycle that starts at the next edge. The receiver cannot
// hold a result off and must take it in that cycle. The table update of an
// event is visible to the event right behind it. The per-cycle path is the
// port match over all SLOTS entries followed by one 32-bit add/compare on
// the selected slot. After reset all slots are free and closed.
module transport_server_connection_fsm
  import tscf_pkg::*;
#(
  parameter int SLOTS        = 8,
  parameter int BUF_BYTES    = 65536,
  parameter int SEG_DATA_MAX = 1500
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  in_t  item_i,
  output logic done_o,
  output out_t result_o
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = ((SW > 3) ? SW : 3) + 1;
  localparam int FW = $clog2(BUF_BYTES + 1);
  localparam int XW = (FW > 17) ? FW : 17;
  localparam int AW = ((FW > 11) ? FW : 11) + 1;

  typedef struct packed {
    logic [15:0]   lport;
    logic [15:0]   pport;
    logic [7:0]    pnode;
    logic [31:0]   exp_seq;
    logic [FW-1:0] fill;
  } entry_t;

  logic        in_vld_q;
  in_t         in_q;
  logic        done_q;
  out_t        res_q, res_d;

  logic        used_q  [SLOTS];
  conn_state_e state_q [SLOTS];
  entry_t      ent_q   [SLOTS];

  logic          hit, free_hit, slot_ok;
  logic [SW-1:0] midx, free_idx, sidx, sel_idx;
  logic [PW-1:0] slot_x, sel_x;
  entry_t        cur, ent_n;
  conn_state_e   cur_st, state_n;
  logic          cur_used, used_n;
  logic [AW-1:0] fill_sum;
  logic [XW-1:0] fill_x;

  assign busy_o = 1'b0;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= item_i;
    end
  end

  // Port match: last in-use slot wins. Free search: lowest free slot wins.
  always_comb begin
    hit      = 1'b0;
    midx     = '0;
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (used_q[i] && ent_q[i].lport == in_q.srv_port) begin
        hit  = 1'b1;
        midx = SW'(i);
      end
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_hit = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign slot_x  = PW'(in_q.slot);
  assign sidx    = slot_x[SW-1:0];
  assign slot_ok = (slot_x < PW'(SLOTS)) && used_q[sidx];

  always_comb begin
    unique case (in_q.mode)
      MODE_SEG:  sel_idx = midx;
      MODE_OPEN: sel_idx = free_idx;
      default:   sel_idx = sidx;
    endcase
  end

  assign sel_x    = PW'(sel_idx);
  assign cur      = ent_q[sel_idx];
  assign cur_st   = state_q[sel_idx];
  assign cur_used = used_q[sel_idx];
  assign fill_x   = XW'(cur.fill);
  assign fill_sum = AW'(cur.fill) + AW'(in_q.seg_len);

  always_comb begin
    res_d   = '0;
    ent_n   = cur;
    state_n = cur_st;
    used_n  = cur_used;

    unique case (in_q.mode)
      MODE_SEG: begin
        res_d.status = STAT_DROP;
        if (hit) begin
          unique case (cur_st)
            CS_LISTEN: begin
              if (in_q.seg_type == SEG_SYN) begin
                ent_n.pnode   = in_q.src_node;
                ent_n.pport   = in_q.cli_port;
                ent_n.exp_seq = in_q.seq_num;
                state_n       = CS_CONN;
                res_d.send_reply = 1'b1;
                res_d.reply_type = RP_SYNACK;
                res_d.status     = STAT_OK;
              end
            end
            CS_CONN: begin
              if (in_q.seg_type == SEG_FIN) begin
                state_n          = CS_CWAIT;
                res_d.send_reply = 1'b1;
                res_d.reply_type = RP_FINACK;
                res_d.status     = STAT_OK;
              end else if (in_q.seg_type == SEG_SYN) begin
                res_d.send_reply = 1'b1;
                res_d.reply_type = RP_SYNACK;
                res_d.status     = STAT_OK;
              end else if (in_q.seg_type == SEG_DATA &&
                           17'(in_q.seg_len) <= 17'(SEG_DATA_MAX)) begin
                if (cur.exp_seq == in_q.seq_num) begin
                  // In order: take it only if it fits, else drop silently
                  if (fill_sum <= AW'(BUF_BYTES)) begin
                    ent_n.fill          = FW'(fill_sum);
                    ent_n.exp_seq       = cur.exp_seq + 32'(in_q.seg_len);
                    res_d.accept_data   = 1'b1;
                    res_d.write_offset  = fill_x[15:0];
                    res_d.send_reply    = 1'b1;
                    res_d.reply_type    = RP_DATAACK;
                    res_d.ack_num       = cur.exp_seq + 32'(in_q.seg_len);
                    res_d.status        = STAT_OK;
                  end
                end else begin
                  res_d.send_reply = 1'b1;
                  res_d.reply_type = RP_DATAACK;
                  res_d.ack_num    = cur.exp_seq;
                  res_d.status     = STAT_OK;
                end
              end
            end
            CS_CWAIT: begin
              if (in_q.seg_type == SEG_FIN) begin
                res_d.send_reply = 1'b1;
                res_d.reply_type = RP_FINACK;
                res_d.status     = STAT_OK;
              end
            end
            default: ;
          endcase
          if (res_d.send_reply) begin
            res_d.reply_from_port = in_q.srv_port;
            res_d.reply_to_port   = in_q.cli_port;
            res_d.reply_node      = ent_n.pnode;
          end
          res_d.slot_out   = sel_x[2:0];
          res_d.slot_state = cs_code(state_n);
          res_d.buf_used   = 17'(ent_n.fill);
        end
      end
      MODE_OPEN: begin
        if (free_hit) begin
          used_n        = 1'b1;
          state_n       = CS_CLOSED;
          ent_n.lport   = in_q.open_port;
          ent_n.pport   = '0;
          ent_n.pnode   = '0;
          ent_n.exp_seq = '0;
          ent_n.fill    = '0;
          res_d.slot_out   = sel_x[2:0];
          res_d.slot_state = cs_code(CS_CLOSED);
          res_d.status     = STAT_OK;
        end else begin
          res_d.status = STAT_NO_SLOT;
        end
      end
      MODE_LISTEN, MODE_READ, MODE_CLOSE: begin
        res_d.slot_out = in_q.slot;
        if (!slot_ok) begin
          res_d.status = STAT_DROP;
        end else begin
          res_d.status = STAT_OK;
          if (in_q.mode == MODE_LISTEN) begin
            state_n = CS_LISTEN;
          end else if (in_q.mode == MODE_READ) begin
            if (fill_x >= XW'(in_q.read_len)) begin
              ent_n.fill = cur.fill - FW'(in_q.read_len);
            end else begin
              res_d.status = STAT_NOT_READY;
            end
          end else begin
            ent_n.fill = '0;
            state_n    = CS_CLOSED;
            used_n     = 1'b0;
          end
          res_d.slot_state = cs_code(state_n);
          res_d.buf_used   = 17'(ent_n.fill);
        end
      end
      default: begin
        res_d.status = STAT_DROP;
      end
    endcase
  end

  // Table write-back: unchanged fields are written with their own value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        used_q[i]  <= 1'b0;
        state_q[i] <= CS_CLOSED;
      end
    end else if (in_vld_q) begin
      used_q[sel_idx]  <= used_n;
      state_q[sel_idx] <= state_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      ent_q[sel_idx] <= ent_n;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // Every accepted event yields exactly one result, through the input and result registers
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("accepted event produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |=> !done_o)
    else $error("result without an accepted event");

  a_reply_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.send_reply) |-> (result_o.status == STAT_OK))
    else $error("reply sent with non-ok status");

  a_accept_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.accept_data) |->
      (result_o.send_reply && result_o.reply_type == RP_DATAACK))
    else $error("accepted data without a data ack");

  a_quiet_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.send_reply) |->
      (result_o.ack_num == '0 && result_o.reply_node == '0 && !result_o.accept_data))
    else $error("reply fields set without a reply");

endmodule

// ===== verif/conn_table_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the server connection table. Keeps its own copy of the
// slot table, predicts one result per accepted event and compares it with
// the strobed result. Depends on tscf_pkg.
module conn_table_checker
  import tscf_pkg::*;
#(
  parameter int SLOTS        = 8,
  parameter int BUF_BYTES    = 65536,
  parameter int SEG_DATA_MAX = 1500
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  in_t                     item_i,
  input  logic                    done_i,
  input  out_t                    result_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output logic [SLOTS-1:0]        used_o,
  output logic [SLOTS-1:0]        listen_o,
  output logic [SLOTS-1:0]        conn_o,
  output logic [SLOTS-1:0]        cwait_o,
  output logic [SLOTS-1:0][15:0]  port_o,
  output logic [SLOTS-1:0][31:0]  seq_o,
  output logic [SLOTS-1:0][16:0]  fill_o
);

  localparam int MAX_REPORTS = 10;

  // Slot state as reported on slot_state
  localparam logic [1:0] ST_CLOSED = 2'd0;
  localparam logic [1:0] ST_LISTEN = 2'd1;
  localparam logic [1:0] ST_CONN   = 2'd2;
  localparam logic [1:0] ST_CWAIT  = 2'd3;

  logic [SLOTS-1:0]       slot_used;
  logic [SLOTS-1:0][1:0]  slot_st;
  logic [SLOTS-1:0][15:0] slot_lport;
  logic [SLOTS-1:0][15:0] slot_pport;
  logic [SLOTS-1:0][7:0]  slot_pnode;
  logic [SLOTS-1:0][31:0] slot_nseq;
  logic [SLOTS-1:0][16:0] slot_fill;

  out_t due_results[$];
  out_t want;

  assign used_o = slot_used;
  assign port_o = slot_lport;
  assign seq_o  = slot_nseq;
  assign fill_o = slot_fill;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      listen_o[i] = slot_st[i] == ST_LISTEN;
      conn_o[i]   = slot_st[i] == ST_CONN;
      cwait_o[i]  = slot_st[i] == ST_CWAIT;
    end
  end

  function automatic out_t with_reply(input out_t r, input reply_e kind, input in_t ev,
                                      input logic [7:0] node, input logic [31:0] ack);
    r.send_reply      = 1'b1;
    r.reply_type      = kind;
    r.reply_from_port = ev.srv_port;
    r.reply_to_port   = ev.cli_port;
    r.reply_node      = node;
    r.ack_num         = ack;
    r.status          = STAT_OK;
    return r;
  endfunction

  task automatic update_slots(input in_t ev, output out_t res);
    int s;
    bit hit;
    res = '0;
    s   = 0;
    hit = 1'b0;
    case (ev.mode)
      MODE_SEG: begin
        // the highest in-use slot on the port wins
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && slot_lport[i] == ev.srv_port) begin
            s   = i;
            hit = 1'b1;
          end
        end
        res.status = STAT_DROP;
        if (hit) begin
          case (slot_st[s])
            ST_LISTEN: begin
              if (ev.seg_type == SEG_SYN) begin
                slot_pnode[s] = ev.src_node;
                slot_pport[s] = ev.cli_port;
                slot_nseq[s]  = ev.seq_num;
                slot_st[s]    = ST_CONN;
                res = with_reply(res, RP_SYNACK, ev, slot_pnode[s], '0);
              end
            end
            ST_CONN: begin
              if (ev.seg_type == SEG_FIN) begin
                slot_st[s] = ST_CWAIT;
                res = with_reply(res, RP_FINACK, ev, slot_pnode[s], '0);
              end else if (ev.seg_type == SEG_SYN) begin
                res = with_reply(res, RP_SYNACK, ev, slot_pnode[s], '0);
              end else if (ev.seg_type == SEG_DATA && int'(ev.seg_len) <= SEG_DATA_MAX) begin
                if (slot_nseq[s] != ev.seq_num) begin
                  // out of order: re-acknowledge what is still awaited
                  res = with_reply(res, RP_DATAACK, ev, slot_pnode[s], slot_nseq[s]);
                end else if (int'(slot_fill[s]) + int'(ev.seg_len) <= BUF_BYTES) begin
                  res.accept_data  = 1'b1;
                  res.write_offset = slot_fill[s][15:0];
                  slot_fill[s]     = slot_fill[s] + 17'(ev.seg_len);
                  slot_nseq[s]     = slot_nseq[s] + 32'(ev.seg_len);
                  res = with_reply(res, RP_DATAACK, ev, slot_pnode[s], slot_nseq[s]);
                end
                // in order but no room left: drop without a reply
              end
            end
            ST_CWAIT: begin
              if (ev.seg_type == SEG_FIN) begin
                res = with_reply(res, RP_FINACK, ev, slot_pnode[s], '0);
              end
            end
            default: ;
          endcase
          res.slot_out   = 3'(s);
          res.slot_state = slot_st[s];
          res.buf_used   = slot_fill[s];
        end
      end
      MODE_OPEN: begin
        res.status = STAT_NO_SLOT;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_used[i]) begin
            s   = i;
            hit = 1'b1;
          end
        end
        if (hit) begin
          slot_used[s]  = 1'b1;
          slot_st[s]    = ST_CLOSED;
          slot_lport[s] = ev.open_port;
          slot_pport[s] = '0;
          slot_pnode[s] = '0;
          slot_nseq[s]  = '0;
          slot_fill[s]  = '0;
          res.slot_out  = 3'(s);
          res.status    = STAT_OK;
        end
      end
      MODE_LISTEN, MODE_READ, MODE_CLOSE: begin
        s = int'(ev.slot);
        res.slot_out = ev.slot;
        if (s >= SLOTS || !slot_used[s]) begin
          res.status = STAT_DROP;
        end else begin
          if (ev.mode == MODE_LISTEN) begin
            slot_st[s] = ST_LISTEN;
          end else if (ev.mode == MODE_READ) begin
            if (slot_fill[s] >= ev.read_len) slot_fill[s] = slot_fill[s] - ev.read_len;
            else res.status = STAT_NOT_READY;
          end else begin
            slot_fill[s] = '0;
            slot_st[s]   = ST_CLOSED;
            slot_used[s] = 1'b0;
          end
          res.slot_state = slot_st[s];
          res.buf_used   = slot_fill[s];
        end
      end
      default: res.status = STAT_DROP;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      fail_count_o++;
      if (fail_count_o <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_used  = '0;
      slot_st    = '0;  // every slot closed
      slot_lport = '0;
      slot_pport = '0;
      slot_pnode = '0;
      slot_nseq  = '0;
      slot_fill  = '0;
      due_results.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      // compare first: a result always belongs to an older event
      if (done_i) begin
        if (due_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t: result strobed with no event outstanding", $time);
        end else begin
          want = due_results.pop_front();
          check_field("send_reply", 32'(want.send_reply), 32'(result_i.send_reply));
          check_field("reply_type", 32'(want.reply_type), 32'(result_i.reply_type));
          check_field("reply_from_port", 32'(want.reply_from_port),
                      32'(result_i.reply_from_port));
          check_field("reply_to_port", 32'(want.reply_to_port),
                      32'(result_i.reply_to_port));
          check_field("reply_node", 32'(want.reply_node), 32'(result_i.reply_node));
          check_field("ack_num", want.ack_num, result_i.ack_num);
          check_field("accept_data", 32'(want.accept_data), 32'(result_i.accept_data));
          check_field("write_offset", 32'(want.write_offset), 32'(result_i.write_offset));
          check_field("slot_out", 32'(want.slot_out), 32'(result_i.slot_out));
          check_field("slot_state", 32'(want.slot_state), 32'(result_i.slot_state));
          check_field("status", 32'(want.status), 32'(result_i.status));
          check_field("buf_used", 32'(want.buf_used), 32'(result_i.buf_used));
        end
      end
      if (start_i && !busy_i) begin
        update_slots(item_i, want);
        due_results.push_back(want);
      end
      pending_o = due_results.size();
    end
  end

endmodule

// ===== verif/tb_transport_server_connection_fsm.sv =====
`timescale 1ns / 100ps
// Top testbench for transport_server_connection_fsm: clock, reset, event
// stimulus with random idle gaps, and the verdict.
// Depends on tscf_pkg and conn_table_checker.
module tb_transport_server_connection_fsm;
  import tscf_pkg::*;

  localparam int SLOTS        = 8;
  localparam int BUF_BYTES    = 65536;
  localparam int SEG_DATA_MAX = 1500;
  localparam int TOTAL_ITEMS  = 1850;
  localparam int CALM_ITEMS   = 300;
  localparam int BURST_EVERY  = 400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  in_t  item_i  = '0;
  logic busy_o;
  logic done_o;
  out_t result_o;

  int fail_n;
  int pending_n;
  int item_n     = 0;
  int cycle_n    = 0;
  int next_burst = 0;
  bit idle_on    = 1'b1;

  logic [SLOTS-1:0]        tbl_used;
  logic [SLOTS-1:0]        tbl_listen;
  logic [SLOTS-1:0]        tbl_conn;
  logic [SLOTS-1:0]        tbl_cwait;
  logic [SLOTS-1:0][15:0]  tbl_port;
  logic [SLOTS-1:0][31:0]  tbl_seq;
  logic [SLOTS-1:0][16:0]  tbl_fill;

  transport_server_connection_fsm #(
    .SLOTS(SLOTS), .BUF_BYTES(BUF_BYTES), .SEG_DATA_MAX(SEG_DATA_MAX)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  conn_table_checker #(
    .SLOTS(SLOTS), .BUF_BYTES(BUF_BYTES), .SEG_DATA_MAX(SEG_DATA_MAX)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .item_i       (item_i),
    .done_i       (done_o),
    .result_i     (result_o),
    .fail_count_o (fail_n),
    .pending_o    (pending_n),
    .used_o       (tbl_used),
    .listen_o     (tbl_listen),
    .conn_o       (tbl_conn),
    .cwait_o      (tbl_cwait),
    .port_o       (tbl_port),
    .seq_o        (tbl_seq),
    .fill_o       (tbl_fill)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic in_t rand_item();
    in_t ev;
    ev.mode      = 3'($urandom);
    ev.slot      = 3'($urandom);
    ev.open_port = 16'($urandom);
    ev.seg_type  = 3'($urandom);
    ev.cli_port  = 16'($urandom);
    ev.srv_port  = 16'($urandom);
    ev.src_node  = 8'($urandom);
    ev.seq_num   = $urandom();
    ev.seg_len   = 11'($urandom);
    ev.read_len  = 17'($urandom);
    return ev;
  endfunction

  // Open, listen, read and close; val is the open port or the read length
  function automatic in_t slot_of(input logic [2:0] md, input logic [2:0] sl,
                                  input logic [16:0] val);
    in_t ev;
    ev           = rand_item();
    ev.mode      = md;
    ev.slot      = sl;
    ev.open_port = val[15:0];
    ev.read_len  = val;
    return ev;
  endfunction

  function automatic in_t seg_of(input logic [2:0] st, input logic [15:0] dport,
                                 input logic [31:0] seq, input logic [10:0] len);
    in_t ev;
    ev           = rand_item();
    ev.mode      = MODE_SEG;
    ev.seg_type  = st;
    ev.srv_port  = dport;
    ev.seq_num   = seq;
    ev.seg_len   = len;
    return ev;
  endfunction

  // Small pool so that ports collide now and then
  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'h8000 | 16'($urandom_range(0, 11));
    endcase
  endfunction

  function automatic logic [10:0] seg_len_pick();
    case ($urandom_range(0, 15))
      0: return 11'($urandom_range(SEG_DATA_MAX + 1, 2047));  // oversize, up to all ones
      1: return '0;
      2: return 11'(SEG_DATA_MAX);
      default: return 11'($urandom_range(1, SEG_DATA_MAX));
    endcase
  endfunction

  function automatic logic [16:0] read_len_pick(input logic [16:0] fill);
    case ($urandom_range(0, 7))
      0: return 17'($urandom);
      1: return fill;
      2: return fill + 17'd1;
      default: return 17'($urandom_range(0, fill));
    endcase
  endfunction

  // Slot that a segment on this port reaches: the highest in-use one
  function automatic logic [2:0] owner(input logic [15:0] port);
    logic [2:0] s;
    s = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_used[i] && tbl_port[i] == port) s = 3'(i);
    end
    return s;
  endfunction

  function automatic in_t next_item();
    in_t ev;
    logic [2:0] s;
    int r;
    ev = rand_item();
    r  = $urandom_range(0, 99);
    if (r < 4) return ev;  // raw noise: any mode, type or port
    if (tbl_used == '0 || r < 12) return slot_of(MODE_OPEN, '0, {1'b0, pick_port()});
    do s = 3'($urandom_range(0, SLOTS - 1)); while (!tbl_used[s]);
    s = owner(tbl_port[s]);
    r = $urandom_range(0, 99);
    if (tbl_conn[s]) begin
      if (r < 65)
        return seg_of(SEG_DATA, tbl_port[s], r < 58 ? tbl_seq[s] : $urandom(), seg_len_pick());
      if (r < 80) return slot_of(MODE_READ, s, read_len_pick(tbl_fill[s]));
      if (r < 85) return seg_of(SEG_SYN, tbl_port[s], $urandom(), seg_len_pick());
      if (r < 90) return seg_of(SEG_FIN, tbl_port[s], $urandom(), seg_len_pick());
      if (r < 96) return seg_of(3'($urandom), tbl_port[s], tbl_seq[s], seg_len_pick());
      return slot_of(r < 98 ? MODE_LISTEN : MODE_CLOSE, s, '0);
    end
    if (tbl_listen[s]) begin
      if (r < 75) return seg_of(SEG_SYN, tbl_port[s], $urandom(), seg_len_pick());
      if (r < 85) return seg_of(3'($urandom), tbl_port[s], $urandom(), seg_len_pick());
      if (r < 92) return slot_of(MODE_READ, s, read_len_pick(tbl_fill[s]));
      return slot_of(MODE_CLOSE, s, '0);
    end
    if (tbl_cwait[s]) begin
      if (r < 30) return seg_of(SEG_FIN, tbl_port[s], $urandom(), seg_len_pick());
      if (r < 65) return slot_of(MODE_CLOSE, s, '0);
      if (r < 85) return seg_of(3'($urandom), tbl_port[s], tbl_seq[s], seg_len_pick());
      return slot_of(r < 93 ? MODE_READ : MODE_LISTEN, s, read_len_pick(tbl_fill[s]));
    end
    if (r < 70) return slot_of(MODE_LISTEN, s, '0);
    if (r < 85) return slot_of(MODE_CLOSE, s, '0);
    return seg_of(3'($urandom), tbl_port[s], $urandom(), seg_len_pick());
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic issue(input in_t ev);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= ev;
    do @(posedge clk_i); while (busy_o);
    item_n++;
    @(negedge clk_i);
  endtask

  function automatic in_t data_of(input logic [2:0] s, input logic [10:0] len);
    return seg_of(SEG_DATA, tbl_port[s], tbl_seq[s], len);
  endfunction

  // Drive one connection to a full buffer, overflow it, then drain it
  task automatic fill_burst();
    logic [2:0] s;
    bit found;
    s     = '0;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_conn[i] && owner(tbl_port[i]) == 3'(i)) begin
        s     = 3'(i);
        found = 1'b1;
      end
    end
    if (found) begin
      issue(slot_of(MODE_READ, s, tbl_fill[s]));
      repeat (BUF_BYTES / SEG_DATA_MAX) issue(data_of(s, 11'(SEG_DATA_MAX)));
      issue(data_of(s, 11'(BUF_BYTES % SEG_DATA_MAX)));  // exact fit
      issue(data_of(s, 11'd1));                          // in order, no room
      issue(data_of(s, '0));                             // empty payload at full
      issue(slot_of(MODE_READ, s, 17'(BUF_BYTES)));
    end
  endtask

  initial begin
    logic [2:0]  m;
    logic [31:0] wrap_seq;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table: unusable slots, unknown modes, unmatched segment
    issue(slot_of(MODE_READ, 3'd0, '0));
    issue(slot_of(MODE_LISTEN, 3'd7, '0));
    issue(slot_of(MODE_CLOSE, 3'd3, '0));
    m = MODE_CLOSE;
    repeat (3) begin
      m = m + 3'd1;
      issue(slot_of(m, 3'd0, '0));
    end
    issue(seg_of(SEG_SYN, 16'h0000, '0, '0));

    issue(slot_of(MODE_OPEN, 3'd0, 17'h0FFFF));
    issue(slot_of(MODE_OPEN, 3'd0, 17'h00000));
    issue(seg_of(SEG_SYN, 16'hFFFF, '0, '0));  // closed slot ignores SYN
    issue(slot_of(MODE_LISTEN, 3'd0, '0));
    wrap_seq = 32'hFFFF_FC00;
    issue(seg_of(SEG_SYN, 16'hFFFF, wrap_seq, '0));
    issue(seg_of(SEG_SYN, 16'hFFFF, 32'hFFFF_FFFF, 11'h7FF));  // repeated SYN
    issue(seg_of(SEG_DATA, 16'hFFFF, wrap_seq, 11'(SEG_DATA_MAX)));  // ack wraps
    issue(seg_of(SEG_DATA, 16'hFFFF, '0, '0));  // out of order
    wrap_seq = wrap_seq + 32'(SEG_DATA_MAX);
    issue(seg_of(SEG_DATA, 16'hFFFF, wrap_seq, 11'h7FF));  // oversize payload
    issue(seg_of(SEG_DATAACK, 16'hFFFF, wrap_seq, '0));
    issue(slot_of(MODE_READ, 3'd0, 17'd100));
    issue(slot_of(MODE_READ, 3'd0, 17'h1FFFF));
    issue(seg_of(SEG_FIN, 16'hFFFF, '0, '0));
    issue(seg_of(SEG_FIN, 16'hFFFF, '0, '0));
    issue(seg_of(SEG_DATA, 16'hFFFF, wrap_seq, 11'd1));  // close-wait drops data
    issue(slot_of(MODE_CLOSE, 3'd0, '0));
    // fill every slot; the last open finds none free
    repeat (SLOTS) issue(slot_of(MODE_OPEN, 3'd0, {1'b0, pick_port()}));

    next_burst = item_n + BURST_EVERY / 2;
    while (item_n < TOTAL_ITEMS) begin
      idle_on = item_n < TOTAL_ITEMS - CALM_ITEMS;
      if (item_n >= next_burst) begin
        fill_burst();
        next_burst += BURST_EVERY;
      end else begin
        issue(next_item());
      end
    end
    start_i <= 1'b0;

    while (pending_n != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_n == 0 && pending_n == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
